// File: hw/rtl/p99ps_pkg.sv
// Package for the p99 percentile selector.
// Holds the controller state type, the tally control struct and the signed compare.
// No dependencies.
package p99ps_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned MOD_W  = 7;
    localparam logic [MOD_W-1:0] MOD_TOP = 7'd99;
    localparam logic [DATA_W-1:0] SIGN_FLIP = 64'h8000_0000_0000_0000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PLACE,
        ST_RANK,
        ST_FETCH
    } ctrl_state_t;

    typedef struct packed {
        logic inc;
        logic drop;
        logic clear;
    } tally_ctrl_t;

    function automatic logic signed_gt(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b);
        signed_gt = (a ^ SIGN_FLIP) > (b ^ SIGN_FLIP);
    endfunction

endpackage

// File: hw/rtl/p99ps_if.sv
// Valid/ready channel interfaces for the p99 percentile selector.
// Depends on p99ps_pkg for the data width.
interface p99ps_in_if;
    import p99ps_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] value;
    logic              last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface p99ps_out_if;
    import p99ps_pkg::*;
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] p99_value;
    logic              overflowed;

    modport source (output valid, output p99_value, output overflowed, input ready);
    modport sink   (input valid, input p99_value, input overflowed, output ready);
endinterface

// File: hw/rtl/p99ps_store.sv
// Sorted sample store: simple dual-port RAM, one write and one registered read per cycle.
// Depends on p99ps_pkg.
module p99ps_store
    import p99ps_pkg::*;
#(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned AW    = 8
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [AW-1:0]     raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/p99ps_tally.sv
// Sample count, overflow flag and running floor(count/100) for the rank.
// rank = count - ceil(count/100) = floor(count*99/100). Depends on p99ps_pkg.
module p99ps_tally
    import p99ps_pkg::*;
#(
    parameter int unsigned MAX_VALUES = 256,
    parameter int unsigned AW         = 8,
    parameter int unsigned CW         = 9
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  tally_ctrl_t ctrl,
    output logic [CW-1:0] count,
    output logic [AW-1:0] rank,
    output logic          full,
    output logic          ovf
);

    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    hund_reg, hund_next;
    logic [MOD_W-1:0] mod_reg, mod_next;
    logic             ovf_reg, ovf_next;
    logic [CW-1:0]    rank_full;

    always_comb
    begin
        count_next = count_reg;
        hund_next  = hund_reg;
        mod_next   = mod_reg;
        ovf_next   = ovf_reg;
        if (ctrl.clear)
        begin
            count_next = '0;
            hund_next  = '0;
            mod_next   = '0;
            ovf_next   = 1'b0;
        end
        else
        begin
            if (ctrl.inc)
            begin
                count_next = count_reg + CW'(1);
                if (mod_reg == MOD_TOP)
                begin
                    mod_next  = '0;
                    hund_next = hund_reg + CW'(1);
                end
                else
                begin
                    mod_next = mod_reg + MOD_W'(1);
                end
            end
            if (ctrl.drop)
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            hund_reg  <= '0;
            mod_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            hund_reg  <= hund_next;
            mod_reg   <= mod_next;
            ovf_reg   <= ovf_next;
        end
    end

    assign rank_full = count_reg - hund_reg - CW'(mod_reg != '0);
    assign rank      = rank_full[AW-1:0];
    assign count     = count_reg;
    assign full      = (count_reg == CW'(MAX_VALUES));
    assign ovf       = ovf_reg;

endmodule

// File: hw/rtl/p99_percentile_select_core.sv
// p99 percentile selector, top level: controller, sorted store and tally.
// Depends on p99ps_pkg, p99ps_if, p99ps_store and p99ps_tally.
//
// Usage: samples arrive on the sink channel (value, last), one per transfer.
// Each sample is inserted into an ascending store held in RAM; equal values go
// after those already held. On a transfer with last set, the result channel
// gives the value at zero-based sorted rank floor(count*99/100) and an
// overflow flag, then the count and flag clear for the next set.
// Samples beyond MAX_VALUES are dropped and mark the set as overflowed.
// Insertion: a sample into an empty or full store is written or dropped in the idle state. Otherwise the
// insertion walks down the store from the top, one RAM read and one write per
// cycle, moving each held sample greater than the new one up by one entry. A
// last sample then adds a rank read and a result load before the result is
// registered.
// The result sits in an output register; the next set's samples are taken
// while it waits. If the receiver still holds a result when the next one is
// ready, the block waits with the input closed. Reset empties the set and
// clears the result valid; the RAM needs no clearing.
module p99_percentile_select_core
    import p99ps_pkg::*;
#(
    parameter int unsigned MAX_VALUES = 256
)
(
    input  logic         clk,
    input  logic         rst_n,
    p99ps_in_if.sink     samples,
    p99ps_out_if.source  result
);

    localparam int unsigned AW = $clog2(MAX_VALUES);
    localparam int unsigned CW = $clog2(MAX_VALUES + 1);

    ctrl_state_t       state_reg, state_next;
    logic [DATA_W-1:0] v_reg, v_next;
    logic              last_reg, last_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_ovf_reg;
    logic              out_load;

    tally_ctrl_t       tctrl;
    logic [CW-1:0]     count;
    logic [AW-1:0]     rank;
    logic              full;
    logic              ovf;
    logic [CW-1:0]     top_idx;

    logic              we;
    logic [AW-1:0]     waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [AW-1:0]     raddr;
    logic [DATA_W-1:0] rdata;

    p99ps_store #(
        .DEPTH (MAX_VALUES),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    p99ps_tally #(
        .MAX_VALUES (MAX_VALUES),
        .AW         (AW),
        .CW         (CW)
    ) u_tally (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tctrl),
        .count (count),
        .rank  (rank),
        .full  (full),
        .ovf   (ovf)
    );

    assign top_idx = count - CW'(1);

    always_comb
    begin
        state_next      = state_reg;
        v_next          = v_reg;
        last_next       = last_reg;
        idx_next        = idx_reg;
        tctrl           = '0;
        we              = 1'b0;
        waddr           = '0;
        wdata           = v_reg;
        re              = 1'b0;
        raddr           = '0;
        out_load        = 1'b0;
        samples.ready   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                samples.ready = 1'b1;
                if (samples.valid)
                begin
                    v_next    = samples.value;
                    last_next = samples.last;
                    if (full)
                    begin
                        tctrl.drop = 1'b1;
                        state_next = samples.last ? ST_RANK : ST_IDLE;
                    end
                    else if (count == '0)
                    begin
                        we         = 1'b1;
                        waddr      = '0;
                        wdata      = samples.value;
                        tctrl.inc  = 1'b1;
                        state_next = samples.last ? ST_RANK : ST_IDLE;
                    end
                    else
                    begin
                        re         = 1'b1;
                        raddr      = top_idx[AW-1:0];
                        idx_next   = top_idx[AW-1:0];
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // write idx+1 and read idx-1: never the same entry
                we    = 1'b1;
                waddr = idx_reg + AW'(1);
                if (signed_gt(rdata, v_reg))
                begin
                    wdata = rdata;
                    if (idx_reg == '0)
                    begin
                        state_next = ST_PLACE;
                    end
                    else
                    begin
                        re       = 1'b1;
                        raddr    = idx_reg - AW'(1);
                        idx_next = idx_reg - AW'(1);
                    end
                end
                else
                begin
                    wdata      = v_reg;
                    tctrl.inc  = 1'b1;
                    state_next = last_reg ? ST_RANK : ST_IDLE;
                end
            end
            ST_PLACE:
            begin
                we         = 1'b1;
                waddr      = '0;
                wdata      = v_reg;
                tctrl.inc  = 1'b1;
                state_next = last_reg ? ST_RANK : ST_IDLE;
            end
            ST_RANK:
            begin
                re         = 1'b1;
                raddr      = rank;
                state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_load    = 1'b1;
                    tctrl.clear = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg    <= v_next;
        last_reg <= last_next;
        idx_reg  <= idx_next;
        if (out_load)
        begin
            out_value_reg <= rdata;
            out_ovf_reg   <= ovf;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.p99_value  = out_value_reg;
    assign result.overflowed = out_ovf_reg;

endmodule

// File: hw/rtl/p99ps_checker.sv
// Port-level checks for p99_percentile_select_core, attached by bind.
// Depends on p99ps_pkg and the top level's channel interfaces.
module p99ps_checker
    import p99ps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              in_last,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [DATA_W-1:0] out_value,
    input  logic              out_ovf
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(out_ovf))
        else $error("result payload changed while stalled");

    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready ##1 !in_ready)
        else $error("input open during rank lookup");

    a_result_after_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result appeared without a lookup");

endmodule

bind p99_percentile_select_core p99ps_checker u_p99ps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .in_last   (samples.last),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_value (result.p99_value),
    .out_ovf   (result.overflowed)
);

// File: bench/tb_p99_percentile_select_core.sv
// Testbench for p99_percentile_select_core: sets of signed samples in, one p99 result per set out.
// Directed table then random sets; results are checked against a sorted-queue predictor or the table's typed values.
// Depends on p99ps_pkg, p99ps_if and the core RTL.
module tb_p99_percentile_select_core;
    import p99ps_pkg::*;

    localparam int unsigned STORE_DEPTH  = 256;
    localparam int unsigned RANDOM_ITEMS = 1030;
    localparam int unsigned HOLD_CYCLES  = 2500;
    localparam int unsigned HOLD_AT      = 15;
    localparam int unsigned TAIL_CYCLES  = 300;
    localparam longint unsigned CYCLE_LIMIT = 1500000;

    localparam logic [DATA_W-1:0] POS_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [DATA_W-1:0] NEG_MIN = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] ALL_ONES = 64'hffff_ffff_ffff_ffff;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last;
        bit                typed;
        logic [DATA_W-1:0] want;
        logic              want_ovf;
    } sample_row_t;

    typedef struct {
        logic [DATA_W-1:0] p99_value;
        logic              overflowed;
    } p99_result_t;

    logic clk = 1'b0;
    logic rst_n;

    p99ps_in_if  samples_ch ();
    p99ps_out_if result_ch ();

    p99_percentile_select_core #(.MAX_VALUES(STORE_DEPTH)) DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (samples_ch),
        .result  (result_ch)
    );

    always #10 clk = ~clk;

    logic signed [DATA_W-1:0] sorted_held[$];
    bit                       set_dropped;
    p99_result_t              p99_expected[$];
    sample_row_t              directed_rows[$];
    int unsigned              mismatches = 0;
    int unsigned              results_seen = 0;
    longint unsigned          cycle_count = 0;
    bit                       send_calm;
    bit                       recv_calm;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Insert one sample; on a last sample give the value at zero-based rank floor(n*99/100) and start a new set.
    function automatic bit take_sample(input logic signed [DATA_W-1:0] v, input logic l,
                                       output logic [DATA_W-1:0] pv, output logic ov);
        int unsigned pos;
        int unsigned n;
        int unsigned rank;
        pv = '0;
        ov = 1'b0;
        if (sorted_held.size() >= STORE_DEPTH)
            set_dropped = 1'b1;
        else
        begin
            pos = sorted_held.size();
            for (int i = 0; i < sorted_held.size(); i++)
            begin
                if (sorted_held[i] > v)
                begin
                    pos = i;
                    break;
                end
            end
            sorted_held.insert(pos, v);
        end
        if (!l)
            return 1'b0;
        n = sorted_held.size();
        rank = (n * 99) / 100;
        if (n == 0)
            rank = 0;
        else if (rank >= n)
            rank = n - 1;
        pv = sorted_held[rank];
        ov = set_dropped;
        sorted_held.delete();
        set_dropped = 1'b0;
        return 1'b1;
    endfunction

    function automatic int unsigned draw_wait(inout bit calm);
        if ($urandom_range(0, 39) == 0)
            calm = !calm;
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic logic [DATA_W-1:0] draw_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return {$urandom, $urandom};
            4, 5:       return 64'($urandom_range(0, 16)) - 64'd8;
            6:
            begin
                case ($urandom_range(0, 3))
                    0:       return POS_MAX;
                    1:       return NEG_MIN;
                    2:       return ALL_ONES;
                    default: return '0;
                endcase
            end
            7:          return NEG_MIN + 64'($urandom_range(0, 7));
            8:          return POS_MAX - 64'($urandom_range(0, 7));
            default:    return {32'h0, $urandom};
        endcase
    endfunction

    task automatic add_row(input logic [DATA_W-1:0] v, input logic l, input bit typed,
                           input logic [DATA_W-1:0] want, input logic want_ovf);
        sample_row_t r;
        r.value    = v;
        r.last     = l;
        r.typed    = typed;
        r.want     = want;
        r.want_ovf = want_ovf;
        directed_rows.push_back(r);
    endtask

    task automatic send_sample(input logic [DATA_W-1:0] v, input logic l, input bit typed,
                               input logic [DATA_W-1:0] want, input logic want_ovf);
        int unsigned gap;
        logic [DATA_W-1:0] pv;
        logic ov;
        p99_result_t res;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid <= 1'b1;
        samples_ch.value <= v;
        samples_ch.last  <= l;
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        if (take_sample(v, l, pv, ov))
        begin
            res.p99_value  = typed ? want : pv;
            res.overflowed = typed ? want_ovf : ov;
            p99_expected.push_back(res);
        end
    endtask

    task automatic check_result(input logic [DATA_W-1:0] got_value, input logic got_ovf);
        p99_result_t exp_res;
        if (p99_expected.size() == 0)
        begin
            mismatches++;
            $display("%0t: result with none pending, got p99_value %h overflowed %b",
                     $time, got_value, got_ovf);
            return;
        end
        exp_res = p99_expected.pop_front();
        if (got_value !== exp_res.p99_value)
        begin
            mismatches++;
            $display("%0t: p99_value expected %h, got %h", $time, exp_res.p99_value, got_value);
        end
        if (got_ovf !== exp_res.overflowed)
        begin
            mismatches++;
            $display("%0t: overflowed expected %b, got %b", $time, exp_res.overflowed, got_ovf);
        end
    endtask

    // Result side; one long hold-off lets the block fill and close its input.
    initial
    begin
        int unsigned wait_n;
        bit held_off;
        held_off = 1'b0;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!held_off && results_seen == HOLD_AT)
            begin
                held_off = 1'b1;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            wait_n = draw_wait(recv_calm);
            if (wait_n > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (wait_n) @(posedge clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge clk);
            while (!result_ch.valid)
                @(posedge clk);
            results_seen++;
            check_result(result_ch.p99_value, result_ch.overflowed);
        end
    end

    initial
    begin
        int unsigned sent;
        int unsigned set_no;
        int unsigned len;
        int unsigned pick;
        rst_n = 1'b0;
        samples_ch.valid = 1'b0;
        samples_ch.value = '0;
        samples_ch.last  = 1'b0;
        set_dropped  = 1'b0;
        send_calm    = 1'b0;
        recv_calm    = 1'b0;

        add_row(POS_MAX,  1'b1, 1'b1, POS_MAX,  1'b0);
        add_row(NEG_MIN,  1'b1, 1'b1, NEG_MIN,  1'b0);
        add_row('0,       1'b1, 1'b1, '0,       1'b0);
        add_row(POS_MAX,  1'b0, 1'b0, '0,       1'b0);
        add_row(NEG_MIN,  1'b1, 1'b1, POS_MAX,  1'b0);
        // equal values
        add_row(ALL_ONES, 1'b0, 1'b0, '0,       1'b0);
        add_row(ALL_ONES, 1'b0, 1'b0, '0,       1'b0);
        add_row(ALL_ONES, 1'b1, 1'b1, ALL_ONES, 1'b0);
        add_row(64'd5,    1'b0, 1'b0, '0,       1'b0);
        add_row(-64'sd5,  1'b0, 1'b0, '0,       1'b0);
        add_row(64'd5,    1'b1, 1'b1, 64'd5,    1'b0);
        // descending: each insert lands at the bottom
        add_row(64'd4,    1'b0, 1'b0, '0,       1'b0);
        add_row(64'd3,    1'b0, 1'b0, '0,       1'b0);
        add_row(64'd2,    1'b0, 1'b0, '0,       1'b0);
        add_row(64'd1,    1'b1, 1'b0, '0,       1'b0);
        add_row(64'd1,    1'b0, 1'b0, '0,       1'b0);
        add_row(NEG_MIN,  1'b0, 1'b0, '0,       1'b0);
        add_row(POS_MAX,  1'b0, 1'b0, '0,       1'b0);
        add_row('0,       1'b1, 1'b0, '0,       1'b0);
        add_row(64'hffff_ffff_0000_0000, 1'b0, 1'b0, '0, 1'b0);
        add_row(64'h0000_0000_ffff_ffff, 1'b1, 1'b0, '0, 1'b0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_sample(directed_rows[i].value, directed_rows[i].last, directed_rows[i].typed,
                        directed_rows[i].want, directed_rows[i].want_ovf);

        // first set overflows the store, second fills it exactly
        sent = 0;
        set_no = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (set_no == 0)
                len = STORE_DEPTH + 7;
            else if (set_no == 1)
                len = STORE_DEPTH;
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 92)
                    len = $urandom_range(1, 8);
                else if (pick < 98)
                    len = $urandom_range(90, 140);
                else
                    len = $urandom_range(STORE_DEPTH - 6, STORE_DEPTH + 14);
            end
            for (int k = 0; k < len; k++)
                send_sample(draw_sample(), (k == len - 1), 1'b0, '0, 1'b0);
            sent += len;
            set_no++;
        end
        samples_ch.valid <= 1'b0;

        while (p99_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
